// ===== src/lrsf_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, payload structs and sequencer states for the line-to-record store framer.
// No dependencies; imported by every module of the block.
package lrsf_pkg;

	localparam int STORE_BYTES = 1024;
	localparam int LINE_MAX    = 256;

	localparam int STORE_WORDS = STORE_BYTES / 4;
	localparam int STORE_CAP   = STORE_WORDS * 4;
	localparam int MAXPAY      = STORE_CAP - 4;
	localparam int LINE_WORDS  = (LINE_MAX + 3) / 4;

	localparam int LW_W   = (LINE_WORDS > 1) ? $clog2(LINE_WORDS) : 1;
	localparam int NW_W   = $clog2(LINE_WORDS + 1);
	localparam int LEN_W  = ($clog2(LINE_MAX + 1) > LW_W + 2) ? $clog2(LINE_MAX + 1) : LW_W + 2;
	localparam int SW_W   = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
	localparam int FILL_W = $clog2(STORE_CAP + 1);
	localparam int LANES  = 4;

	localparam logic [7:0] NEWLINE   = 8'd10;
	localparam logic       KIND_BYTE = 1'b0;
	localparam logic       KIND_READ = 1'b1;

	typedef struct packed {
		logic       kind;
		logic [7:0] rx_byte;
		logic       chunk_end;
		logic [7:0] read_address;
	} req_t;

	typedef struct packed {
		logic        record_valid;
		logic [9:0]  record_offset;
		logic [8:0]  record_length;
		logic        store_cleared;
		logic        line_overflow;
		logic [31:0] read_data;
	} rsp_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PLAN,
		S_LEN,
		S_DATA,
		S_RESULT,
		S_READ
	} state_t;

	// Line buffer control: one byte write and one word read per cycle.
	typedef struct packed {
		logic             wr_en;
		logic [LW_W-1:0]  wr_word;
		logic [1:0]       wr_lane;
		logic [7:0]       wr_byte;
		logic             rd_en;
		logic [LW_W-1:0]  rd_word;
		logic [LEN_W-1:0] rd_len;
	} lb_cmd_t;

endpackage

// ===== src/line_to_record_store_framer.sv =====
`timescale 1ns / 1ps
// Top level of the line-to-record store framer: sequencer, record store and output register.
// Depends on lrsf_pkg and lrsf_line_buf.
//
// Received bytes (kind 0) are gathered into a line buffer; a newline turns the line into a
// record in a 32-bit word store: one length word, then the payload packed little-endian and
// zero padded to whole words. Records are appended at the fill level; when the free space is
// too small, earlier records are dropped and the record goes to offset 0 (store_cleared).
// Lines longer than LINE_MAX are cut and flagged with line_overflow. A byte with chunk_end
// set that is not a newline discards the unfinished line after it is taken. A read item
// (kind 1) returns one store word; addresses beyond the store read as zero, and words never
// written read as undefined. Each newline and each read gives exactly one result transaction;
// other bytes give none. An ordinary byte does not stall the request channel; a read holds it
// through S_READ, and a newline through S_PLAN, S_LEN, S_DATA and S_RESULT, where the single
// store write port is driven by the sequencer with one word per cycle. A finished result
// sits in the output register; new transactions are taken while it waits, but a read or
// newline cannot finish until the register is free.
module line_to_record_store_framer (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  lrsf_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output lrsf_pkg::rsp_t rsp
);
	import lrsf_pkg::*;

	state_t state_q, state_d;

	logic [LEN_W-1:0]  line_count_q;
	logic              ovf_seen_q;
	logic [FILL_W-1:0] fill_q;
	logic              rsp_valid_q;
	rsp_t              rsp_q;

	logic [LEN_W-1:0]  len_q;
	logic              ovf_q;
	logic [FILL_W-1:0] off_q;
	logic              cleared_q;
	logic [NW_W-1:0]   nwords_q;
	logic [NW_W-1:0]   w_q;
	logic [SW_W-1:0]   wa_q;
	logic              rd_inrange_q;

	logic [31:0] store_mem [STORE_WORDS];
	logic [31:0] store_rd_q;

	logic              accept, is_nl, is_read, is_byte, rsp_free;
	logic              st_we;
	logic [31:0]       st_wdata;
	logic              len_cut;
	logic [FILL_W-1:0] plan_padded, plan_reserve, plan_free, plan_off;
	logic              plan_clear;
	logic [31:0]       lb_data;
	lb_cmd_t           lb_cmd;

	assign req_stall = (state_q != S_IDLE);
	assign accept    = req_valid && !req_stall;
	assign is_read   = (req.kind == KIND_READ);
	assign is_nl     = (req.kind == KIND_BYTE) && (req.rx_byte == NEWLINE);
	assign is_byte   = (req.kind == KIND_BYTE) && !is_nl;
	assign rsp_free  = !rsp_valid_q || !rsp_stall;

	// Cut a line that cannot fit in an empty store.
	assign len_cut = 32'(line_count_q) > MAXPAY;

	// Record placement: pad to whole words, add the length word, clear when it does not fit.
	assign plan_padded  = (FILL_W'(len_q) + FILL_W'(3)) & ~FILL_W'(3);
	assign plan_reserve = plan_padded + FILL_W'(4);
	assign plan_free    = FILL_W'(STORE_CAP) - fill_q;
	assign plan_clear   = (fill_q > FILL_W'(STORE_CAP)) || (plan_free < plan_reserve);
	assign plan_off     = plan_clear ? '0 : fill_q;

	// Sequencer: next state and store write strobe.
	always_comb begin
		state_d  = state_q;
		st_we    = 1'b0;
		st_wdata = lb_data;
		case (state_q)
			S_IDLE: begin
				if (accept && is_read)
					state_d = S_READ;
				else if (accept && is_nl)
					state_d = S_PLAN;
			end
			S_PLAN: state_d = S_LEN;
			S_LEN: begin
				st_we    = 1'b1;
				st_wdata = 32'(len_q);
				state_d  = (nwords_q == '0) ? S_RESULT : S_DATA;
			end
			S_DATA: begin
				st_we = 1'b1;
				if (w_q == nwords_q - NW_W'(1))
					state_d = S_RESULT;
			end
			S_RESULT: if (rsp_free) state_d = S_IDLE;
			S_READ:   if (rsp_free) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	always_comb begin
		lb_cmd.wr_en   = accept && is_byte && (32'(line_count_q) < LINE_MAX);
		lb_cmd.wr_word = line_count_q[2 +: LW_W];
		lb_cmd.wr_lane = line_count_q[1:0];
		lb_cmd.wr_byte = req.rx_byte;
		lb_cmd.rd_en   = (state_q == S_LEN) || (state_q == S_DATA);
		lb_cmd.rd_word = (state_q == S_LEN) ? '0 : LW_W'(w_q + NW_W'(1));
		lb_cmd.rd_len  = len_q;
	end

	lrsf_line_buf u_line_buf (
		.clk     (clk),
		.cmd     (lb_cmd),
		.rd_data (lb_data)
	);

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			line_count_q <= '0;
			ovf_seen_q   <= 1'b0;
			fill_q       <= '0;
			rsp_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept && is_nl) begin
				line_count_q <= '0;
				ovf_seen_q   <= 1'b0;
			end else if (accept && is_byte) begin
				if (req.chunk_end) begin
					// drop the unfinished line
					line_count_q <= '0;
					ovf_seen_q   <= 1'b0;
				end else if (32'(line_count_q) < LINE_MAX) begin
					line_count_q <= line_count_q + LEN_W'(1);
				end else begin
					ovf_seen_q <= 1'b1;
				end
			end
			if (state_q == S_PLAN)
				fill_q <= plan_off + plan_reserve;
			if ((state_q == S_RESULT || state_q == S_READ) && rsp_free)
				rsp_valid_q <= 1'b1;
			else if (rsp_valid_q && !rsp_stall)
				rsp_valid_q <= 1'b0;
		end
	end

	// Working registers of the current transaction and the result payload.
	always_ff @(posedge clk) begin
		if (accept && is_nl) begin
			len_q <= len_cut ? LEN_W'(MAXPAY) : line_count_q;
			ovf_q <= ovf_seen_q || len_cut;
		end
		if (accept && is_read)
			rd_inrange_q <= 32'(req.read_address) < STORE_WORDS;
		if (state_q == S_PLAN) begin
			off_q     <= plan_off;
			cleared_q <= plan_clear;
			nwords_q  <= NW_W'(plan_padded >> 2);
			wa_q      <= SW_W'(plan_off >> 2);
		end
		if (state_q == S_LEN)
			w_q <= '0;
		else if (state_q == S_DATA)
			w_q <= w_q + NW_W'(1);
		if (st_we)
			wa_q <= wa_q + SW_W'(1);
		if (state_q == S_RESULT && rsp_free) begin
			rsp_q.record_valid  <= 1'b1;
			rsp_q.record_offset <= 10'(off_q);
			rsp_q.record_length <= 9'(len_q);
			rsp_q.store_cleared <= cleared_q;
			rsp_q.line_overflow <= ovf_q;
			rsp_q.read_data     <= '0;
		end else if (state_q == S_READ && rsp_free) begin
			rsp_q.record_valid  <= 1'b0;
			rsp_q.record_offset <= '0;
			rsp_q.record_length <= '0;
			rsp_q.store_cleared <= 1'b0;
			rsp_q.line_overflow <= 1'b0;
			rsp_q.read_data     <= rd_inrange_q ? store_rd_q : 32'd0;
		end
	end

	// Record store: one write port for the sequencer, one read port for read transactions.
	always_ff @(posedge clk) begin
		if (st_we)
			store_mem[wa_q] <= st_wdata;
		if (accept && is_read)
			store_rd_q <= store_mem[SW_W'(req.read_address)];
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// A result only appears when the sequencer finishes a newline or a read.
	a_rsp_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> ($past(state_q) == S_RESULT || $past(state_q) == S_READ))
		else $error("result without a finishing newline or read");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(fill_q) <= STORE_CAP)
		else $error("fill level beyond store capacity");

	a_line_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(line_count_q) <= LINE_MAX)
		else $error("line count beyond line buffer");

	// Record words never run past the end of the store.
	a_store_addr: assert property (@(posedge clk) disable iff (!arst_n)
		st_we |-> 32'(wa_q) < STORE_WORDS)
		else $error("store write address out of range");

	// A pending result that is stalled cannot be overwritten.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_stall) |=> $stable(rsp_q))
		else $error("stalled result changed");

endmodule

// ===== src/lrsf_line_buf.sv =====
`timescale 1ns / 1ps
// Line buffer: four byte lanes of LINE_WORDS entries, read one 32-bit word at a time.
// Depends on lrsf_pkg for sizes and the command struct.
module lrsf_line_buf (
	input  logic             clk,
	input  lrsf_pkg::lb_cmd_t cmd,
	output logic [31:0]      rd_data
);
	import lrsf_pkg::*;

	logic [LW_W-1:0]  rd_word_s1;
	logic [LEN_W-1:0] rd_len_s1;

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rd_word_s1 <= cmd.rd_word;
			rd_len_s1  <= cmd.rd_len;
		end
	end

	for (genvar l = 0; l < LANES; l++) begin : g_lane
		logic [7:0] mem [LINE_WORDS];
		logic [7:0] rd_q;

		always_ff @(posedge clk) begin
			if (cmd.wr_en && cmd.wr_lane == 2'(l))
				mem[cmd.wr_word] <= cmd.wr_byte;
			if (cmd.rd_en)
				rd_q <= mem[cmd.rd_word];
		end

		// Zero bytes past the line end so padding is clean.
		assign rd_data[8*l +: 8] = (32'({rd_word_s1, 2'(l)}) < 32'(rd_len_s1)) ? rd_q : 8'd0;
	end

endmodule

// ===== tb/sv/line_to_record_store_framer_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the line-to-record store framer: queued stimulus, clocked driver
// and monitor, and a cycle-free predictor of records and store words. Depends on lrsf_pkg.
module line_to_record_store_framer_test;

	import lrsf_pkg::*;

	localparam int RANDOM_ITEMS = 180;  // on top of about 920 directed items
	localparam int DRAIN_CYCLES = 100;  // longer than the slowest newline
	localparam int QUIET_LIMIT  = 1000; // cycles with no transaction on either channel

	typedef struct {
		req_t        item;
		int unsigned lead;   // idle cycles before the item is offered
	} pending_t;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	// Pending requests, filled up front and drained by the driver.
	pending_t    tx_queue [$];
	pending_t    staged;
	bit          have_staged = 1'b0;
	int unsigned lead_max    = 10;

	// Predicted responses in arrival order.
	rsp_t        predicted_rsps [$];
	rsp_t        want;
	int unsigned hold_left   = 0;
	int unsigned hold_max    = 10;
	int unsigned retire_count = 0;
	int unsigned quiet_cycles = 0;
	bit          failed      = 1'b0;

	// Shadow of the framer state.
	logic [7:0]  line_mem  [LINE_MAX];
	int unsigned line_len  = 0;
	bit          line_cut  = 1'b0;
	int unsigned fill      = 0;
	logic [31:0] store_mem [STORE_WORDS];
	int unsigned written_words = 0;  // store words 0 .. written_words-1 hold known data

	line_to_record_store_framer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Apply one accepted request to the shadow state and queue the response it causes.
	function automatic void advance_framer(input req_t r);
		rsp_t        e;
		int unsigned len, padded, reserve, off, base, i, b;
		logic [31:0] w;
		bit          cut;
		e = '0;
		if (r.kind == KIND_READ) begin
			e.read_data = (r.read_address < STORE_WORDS) ? store_mem[r.read_address] : '0;
			predicted_rsps.push_back(e);
		end else if (r.rx_byte == NEWLINE) begin
			len = line_len;
			cut = line_cut;
			if (len > MAXPAY) begin
				len = MAXPAY;
				cut = 1'b1;
			end
			padded  = (len + 3) & ~32'd3;
			reserve = padded + 4;
			// Not enough room behind the fill level: drop everything, restart at zero.
			if (fill > STORE_CAP || STORE_CAP - fill < reserve) begin
				off             = 0;
				fill            = reserve;
				e.store_cleared = 1'b1;
			end else begin
				off  = fill;
				fill = fill + reserve;
			end
			base = off / 4;
			store_mem[base % STORE_WORDS] = len;
			for (i = 0; i < padded / 4; i++) begin
				w = '0;
				for (b = 0; b < 4; b++)
					if (i * 4 + b < len && i * 4 + b < LINE_MAX)
						w[8 * b +: 8] = line_mem[i * 4 + b];
				store_mem[(base + 1 + i) % STORE_WORDS] = w;
			end
			if (base + 1 + padded / 4 > written_words)
				written_words = base + 1 + padded / 4;
			e.record_valid  = 1'b1;
			e.record_offset = off[9:0];
			e.record_length = len[8:0];
			e.line_overflow = cut;
			predicted_rsps.push_back(e);
			line_len = 0;
			line_cut = 1'b0;
		end else begin
			if (line_len < LINE_MAX) begin
				line_mem[line_len] = r.rx_byte;
				line_len++;
			end else begin
				line_cut = 1'b1;
			end
			if (r.chunk_end) begin
				line_len = 0;
				line_cut = 1'b0;
			end
		end
	endfunction

	task automatic compare_field(input string name, input logic [31:0] exp_val,
			input logic [31:0] act_val);
		if (exp_val !== act_val) begin
			$error("%s mismatch: expected %0h, actual %0h", name, exp_val, act_val);
			failed = 1'b1;
		end
	endtask

	function automatic logic [7:0] content_byte();
		logic [7:0] v;
		do v = 8'($urandom_range(0, 255)); while (v == NEWLINE);
		return v;
	endfunction

	task automatic queue_req(input logic kind, input logic [7:0] rx, input logic cend,
			input logic [7:0] addr);
		pending_t p;
		p.item.kind         = kind;
		p.item.rx_byte      = rx;
		p.item.chunk_end    = cend;
		p.item.read_address = addr;
		p.lead              = $urandom_range(0, lead_max);
		tx_queue.push_back(p);
	endtask

	// n payload bytes and a terminating newline.
	task automatic queue_line(input int unsigned n, input logic nl_cend);
		repeat (n) queue_req(KIND_BYTE, content_byte(), 1'b0, 8'($urandom_range(0, 255)));
		queue_req(KIND_BYTE, NEWLINE, nl_cend, 8'($urandom_range(0, 255)));
	endtask

	// n payload bytes, the last one closing the chunk with no newline.
	task automatic queue_chunk(input int unsigned n);
		repeat (n - 1) queue_req(KIND_BYTE, content_byte(), 1'b0, 8'($urandom_range(0, 255)));
		queue_req(KIND_BYTE, content_byte(), 1'b1, 8'($urandom_range(0, 255)));
	endtask

	task automatic queue_read(input logic [7:0] addr);
		queue_req(KIND_READ, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), addr);
	endtask

	// Driver: hold the offered request while stalled, predict on acceptance, then idle for
	// the next item's lead before offering it.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req       <= '0;
		end else begin
			if (req_valid && !req_stall)
				advance_framer(req);
			if (!(req_valid && req_stall)) begin
				if (!have_staged && tx_queue.size() != 0) begin
					staged      = tx_queue.pop_front();
					have_staged = 1'b1;
				end
				if (have_staged && staged.lead == 0) begin
					// Fold reads onto words that hold data; the prediction is current here.
					if (staged.item.kind == KIND_READ && written_words != 0 &&
							staged.item.read_address >= written_words)
						staged.item.read_address = 8'(staged.item.read_address % written_words);
					req         <= staged.item;
					req_valid   <= 1'b1;
					have_staged = 1'b0;
				end else begin
					req_valid <= 1'b0;
					if (have_staged)
						staged.lead--;
				end
			end
		end
	end

	// Monitor: check each response against the oldest prediction, then stall for a drawn
	// number of cycles. Change the stall budget every 32 responses to mix calm and busy runs.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
			hold_left = 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (predicted_rsps.size() == 0) begin
					$error("response with no prediction pending: %p", rsp);
					failed = 1'b1;
				end else begin
					want = predicted_rsps.pop_front();
					compare_field("record_valid", 32'(want.record_valid),
						32'(rsp.record_valid));
					compare_field("record_offset", 32'(want.record_offset),
						32'(rsp.record_offset));
					compare_field("record_length", 32'(want.record_length),
						32'(rsp.record_length));
					compare_field("store_cleared", 32'(want.store_cleared),
						32'(rsp.store_cleared));
					compare_field("line_overflow", 32'(want.line_overflow),
						32'(rsp.line_overflow));
					compare_field("read_data", want.read_data, rsp.read_data);
				end
				retire_count++;
				if (retire_count % 32 == 0)
					hold_max = ($urandom_range(0, 2) == 0) ? 0 : 10;
				hold_left = $urandom_range(0, hold_max);
			end else if (hold_left != 0) begin
				hold_left--;
			end
			rsp_stall <= (hold_left != 0);
		end
	end

	// Watchdog: a run of cycles with no transaction on either channel means a hang.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("line_to_record_store_framer test failed");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		int unsigned target, pick, n;

		// Directed part. Start with a record so every later read has written data.
		queue_line(0, 1'b0);           // empty line: length word only, offset 0
		queue_read(8'd0);
		queue_line(3, 1'b0);           // three bytes padded with one zero byte
		queue_read(8'd1);
		queue_read(8'd2);
		queue_line(LINE_MAX + 2, 1'b1); // long line: cut and flagged; newline also ends chunk
		queue_line(LINE_MAX, 1'b0);    // exactly full line buffer, no cut
		repeat (123) queue_line(0, 1'b0); // fill the store up to its last word
		queue_read(8'd255);
		queue_line(0, 1'b0);           // no free space left: store cleared, back to offset 0
		queue_read(8'd255);
		queue_read(8'd0);
		queue_chunk(2);                // chunk end mid line: discard it
		queue_line(0, 1'b0);
		queue_chunk(LINE_MAX + 2);     // chunk end after a cut: drop the overflow mark too
		queue_line(1, 1'b0);
		queue_req(KIND_READ, 8'hFF, 1'b1, 8'hFF);
		queue_req(KIND_BYTE, 8'h00, 1'b0, 8'hFF);
		queue_req(KIND_BYTE, 8'hFF, 1'b0, 8'h00);
		queue_req(KIND_BYTE, NEWLINE, 1'b0, 8'hFF);

		// Random part: mostly well-formed lines, with reads, broken chunks and noise mixed in.
		target = tx_queue.size() + RANDOM_ITEMS;
		while (tx_queue.size() < target) begin
			lead_max = ($urandom_range(0, 3) == 0) ? 0 : 10;
			pick     = $urandom_range(0, 99);
			if (pick < 60) begin
				n = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 300) : $urandom_range(0, 16);
				queue_line(n, 1'($urandom_range(0, 1)));
			end else if (pick < 80) begin
				repeat ($urandom_range(1, 3)) queue_read(8'($urandom_range(0, 255)));
			end else if (pick < 90) begin
				queue_chunk($urandom_range(1, 8));
			end else begin
				repeat ($urandom_range(1, 5))
					queue_req(KIND_BYTE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
						8'($urandom_range(0, 255)));
			end
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Wait for the last request to go in, then for every prediction to be met.
		do @(posedge clk); while (have_staged || tx_queue.size() != 0 || req_valid);
		do @(posedge clk); while (predicted_rsps.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (!failed && predicted_rsps.size() == 0)
			$display("line_to_record_store_framer test passed");
		else
			$display("line_to_record_store_framer test failed");
		$finish;
	end

endmodule
